// File: rtl/msu_pkg.sv
// ============================================================================
// msu_pkg - shared types and constants of the motor drive supervisor
// Field widths, register indexes, sequencer codes and the item structs
// passed between the supervisor modules.
// ============================================================================
`default_nettype none

package msu_pkg;

    // ADC full-scale width; the zero-current midscale follows from it
    localparam int ADC_BITS = 12;
    localparam int ADC_MID  = 1 << (ADC_BITS - 1);

    // Item field widths
    localparam int ADC_W     = 12;
    localparam int DELTA_W   = 16;
    localparam int IQ_W      = 16;
    localparam int LIMIT_W   = 15;
    localparam int POS_W     = 18;
    localparam int CUR_W     = 13;
    localparam int THETA_W   = 32;
    localparam int STATE_W   = 3;
    localparam int ERR_W     = 2;
    localparam int TRIP_W    = 8;
    localparam int WORD_W    = 16;

    // Current arithmetic width: sample or midscale plus sign and carry
    localparam int CALC_W = ((ADC_BITS > ADC_W) ? ADC_BITS : ADC_W) + 2;
    // Position arithmetic width: base plus delta plus one wrap step
    localparam int POS_CALC_W = POS_W + 2;

    // Stream widths (whole bytes)
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 104;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IQ_LIMIT       = 3'd0,
        REG_LV_THRESHOLD   = 3'd1,
        REG_OV_THRESHOLD   = 3'd2,
        REG_DISCHARGE_THR  = 3'd3,
        REG_OV_TRIP_COUNT  = 3'd4,
        REG_COUNTS_PER_REV = 3'd5,
        REG_INDEX_POSITION = 3'd6,
        REG_ANGLE_STEP     = 3'd7
    } cfg_reg_t;

    // Register reset values
    localparam logic [LIMIT_W-1:0] RST_IQ_LIMIT       = 15'd2560;
    localparam logic [ADC_W-1:0]   RST_LV_THRESHOLD   = 12'd955;
    localparam logic [ADC_W-1:0]   RST_OV_THRESHOLD   = 12'd3436;
    localparam logic [ADC_W-1:0]   RST_DISCHARGE_THR  = 12'd2863;
    localparam logic [TRIP_W-1:0]  RST_OV_TRIP_COUNT  = 8'd5;
    localparam logic [WORD_W-1:0]  RST_COUNTS_PER_REV = 16'd2000;
    localparam logic [WORD_W-1:0]  RST_INDEX_POSITION = 16'd1500;
    localparam logic [WORD_W-1:0]  RST_ANGLE_STEP     = 16'd3294;

    // Reported motor state codes
    localparam logic [STATE_W-1:0] MODE_READY = 3'd0;
    localparam logic [STATE_W-1:0] MODE_START = 3'd1;
    localparam logic [STATE_W-1:0] MODE_RUN   = 3'd2;
    localparam logic [STATE_W-1:0] MODE_STOP  = 3'd3;
    localparam logic [STATE_W-1:0] MODE_ERROR = 3'd4;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNDER = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVER  = 2'd2;

    localparam logic [TRIP_W-1:0] TICKS_MAX = '1;

    typedef struct packed {
        logic [LIMIT_W-1:0] iq_limit;
        logic [ADC_W-1:0]   lv_threshold;
        logic [ADC_W-1:0]   ov_threshold;
        logic [ADC_W-1:0]   discharge_threshold;
        logic [TRIP_W-1:0]  ov_trip_count;
        logic [WORD_W-1:0]  counts_per_rev;
        logic [WORD_W-1:0]  index_position;
        logic [WORD_W-1:0]  angle_step;
    } cfg_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0] encoder_delta;
        logic                      index_pulse;
        logic [ADC_W-1:0]          adc_phase_b;
        logic [ADC_W-1:0]          adc_phase_c;
        logic [ADC_W-1:0]          adc_vbus;
        logic                      run_request;
        logic signed [IQ_W-1:0]    iq_request;
    } tick_in_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  position;
        logic signed [CUR_W-1:0]  current_a;
        logic signed [CUR_W-1:0]  current_b;
        logic signed [CUR_W-1:0]  current_c;
        logic signed [IQ_W-1:0]   iq_limited;
        logic [STATE_W-1:0]       motor_state;
        logic [ERR_W-1:0]         error_code;
        logic                     gate_enable;
        logic                     pwm_enable;
        logic                     fault_led;
        logic                     discharge_on;
        logic                     foc_step;
    } tick_res_t;

endpackage

`default_nettype wire

// File: rtl/motor_drive_supervisor_unit.sv
// ============================================================================
// motor_drive_supervisor_unit - motor drive supervisor top level
// Position tracking, phase currents, Iq clamp, sequencer and bus protection.
// ============================================================================
// Usage:
//   One input item on s_axis is one control tick and yields exactly one result
//   item on m_axis, in order. Items enter through an input register, pass the
//   tick logic into a stage register, then the angle multiplier into the
//   output register, which drives m_axis_tvalid. Throughput is one item per
//   cycle while m_axis accepts; each register stage moves on as soon as the
//   one after it is empty or draining, so s_axis_tready stays high while a
//   result waits as long as a stage in front of it is free. When m_axis is
//   stalled the pipeline fills and s_axis_tready drops after three items.
//   The cfg channel (always ready) writes one setting per cycle by index;
//   write only while no item is in flight.
//   Reset clears the pipeline, sets the sequencer to ready with no fault,
//   clears position, overvoltage tick count and all latches, and loads the
//   default settings.
// ============================================================================
`default_nettype none

module motor_drive_supervisor_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // encoder_delta, adc_phase_b, adc_phase_c, adc_vbus, run_request, iq_request
    input  wire logic [msu_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // index_pulse
    input  wire logic                           s_axis_tuser,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // theta, current_a, current_b, current_c, iq_limited, motor_state,
    // error_code, gate_enable, pwm_enable, fault_led, discharge_on, foc_step
    output logic [msu_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [msu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [msu_pkg::CFG_DATA_W-1:0] cfg_data
);
    import msu_pkg::*;

    cfg_t      cfg;
    tick_in_t  tin_reg, tin_next;
    tick_res_t res;

    logic in_valid_reg, in_valid_next;
    logic mid_valid_reg, mid_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_en, mid_en, in_en;

    assign cfg_ready = 1'b1;

    msu_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stage enables: a stage moves when empty or when the next one moves
    assign out_en = !out_valid_reg || m_axis_tready;
    assign mid_en = !mid_valid_reg || out_en;
    assign in_en  = !in_valid_reg || mid_en;
    assign s_axis_tready = in_en;

    // Unpack the input item
    always_comb
    begin
        tin_next.encoder_delta = signed'(s_axis_tdata[15:0]);
        tin_next.index_pulse   = s_axis_tuser;
        tin_next.adc_phase_b   = s_axis_tdata[27:16];
        tin_next.adc_phase_c   = s_axis_tdata[39:28];
        tin_next.adc_vbus      = s_axis_tdata[51:40];
        tin_next.run_request   = s_axis_tdata[52];
        tin_next.iq_request    = signed'(s_axis_tdata[68:53]);
    end

    always_comb
    begin
        in_valid_next  = in_en  ? s_axis_tvalid : in_valid_reg;
        mid_valid_next = mid_en ? in_valid_reg  : mid_valid_reg;
        out_valid_next = out_en ? mid_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the item on acceptance
    always_ff @(posedge clk)
    begin
        if (in_en && s_axis_tvalid)
            tin_reg <= tin_next;
    end

    msu_tick_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (mid_en && in_valid_reg),
        .cfg   (cfg),
        .tin   (tin_reg),
        .res   (res)
    );

    msu_out_stage u_out (
        .clk        (clk),
        .load       (out_en && mid_valid_reg),
        .res        (res),
        .angle_step (cfg.angle_step),
        .tdata      (m_axis_tdata)
    );

    assign m_axis_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// File: rtl/msu_cfg_regs.sv
// ============================================================================
// msu_cfg_regs - configuration register file
// Holds the eight supervisor settings, written one at a time by index.
// ============================================================================
`default_nettype none

module msu_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic [msu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [msu_pkg::CFG_DATA_W-1:0] cfg_data,
    output msu_pkg::cfg_t                      cfg
);
    import msu_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write index
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IQ_LIMIT:       cfg_next.iq_limit            = cfg_data[LIMIT_W-1:0];
                REG_LV_THRESHOLD:   cfg_next.lv_threshold        = cfg_data[ADC_W-1:0];
                REG_OV_THRESHOLD:   cfg_next.ov_threshold        = cfg_data[ADC_W-1:0];
                REG_DISCHARGE_THR:  cfg_next.discharge_threshold = cfg_data[ADC_W-1:0];
                REG_OV_TRIP_COUNT:  cfg_next.ov_trip_count       = cfg_data[TRIP_W-1:0];
                REG_COUNTS_PER_REV: cfg_next.counts_per_rev      = cfg_data[WORD_W-1:0];
                REG_INDEX_POSITION: cfg_next.index_position      = cfg_data[WORD_W-1:0];
                REG_ANGLE_STEP:     cfg_next.angle_step          = cfg_data[WORD_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.iq_limit            <= RST_IQ_LIMIT;
            cfg_reg.lv_threshold        <= RST_LV_THRESHOLD;
            cfg_reg.ov_threshold        <= RST_OV_THRESHOLD;
            cfg_reg.discharge_threshold <= RST_DISCHARGE_THR;
            cfg_reg.ov_trip_count       <= RST_OV_TRIP_COUNT;
            cfg_reg.counts_per_rev      <= RST_COUNTS_PER_REV;
            cfg_reg.index_position      <= RST_INDEX_POSITION;
            cfg_reg.angle_step          <= RST_ANGLE_STEP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/msu_tick_core.sv
// ============================================================================
// msu_tick_core - per-tick supervisor logic
// Tracks encoder position, forms phase currents, clamps Iq, and steps the
// motor sequencer and bus voltage protection once per item.
// ============================================================================
`default_nettype none

module msu_tick_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire msu_pkg::cfg_t     cfg,
    input  wire msu_pkg::tick_in_t tin,
    output msu_pkg::tick_res_t     res
);
    import msu_pkg::*;

    typedef enum logic [4:0] {
        ST_READY = 5'b00001,
        ST_START = 5'b00010,
        ST_RUN   = 5'b00100,
        ST_STOP  = 5'b01000,
        ST_ERROR = 5'b10000
    } mode_t;

    function automatic logic [STATE_W-1:0] mode_code(input mode_t m);
        logic [STATE_W-1:0] c;
        case (m)
            ST_READY: c = MODE_READY;
            ST_START: c = MODE_START;
            ST_RUN:   c = MODE_RUN;
            ST_STOP:  c = MODE_STOP;
            ST_ERROR: c = MODE_ERROR;
            default:  c = MODE_READY;
        endcase
        return c;
    endfunction

    // Persistent state
    logic signed [POS_W-1:0] pos_reg, pos_next;
    mode_t                   mode_reg, mode_next;
    logic [ERR_W-1:0]        fault_reg, fault_next;
    logic [TRIP_W-1:0]       over_reg, over_next;
    logic                    gate_reg, gate_next;
    logic                    pwm_reg, pwm_next;
    logic                    led_reg, led_next;
    logic                    dis_reg, dis_next;

    // Result payload
    logic signed [CUR_W-1:0] cur_a_reg, cur_b_reg, cur_c_reg;
    logic signed [IQ_W-1:0]  iq_reg, iq_next;
    logic                    foc_reg, foc_next;

    logic signed [POS_CALC_W-1:0] pos_base, pos_sum, pos_wrap, cpr_s;
    logic signed [CALC_W-1:0]     mid_s, cur_a, cur_b, cur_c;
    logic signed [IQ_W:0]         req_s, lim_s, neg_lim_s;

    // Load position on index, add delta, apply one wrap
    always_comb
    begin
        cpr_s    = signed'(POS_CALC_W'(cfg.counts_per_rev));
        pos_base = tin.index_pulse ? signed'(POS_CALC_W'(cfg.index_position))
                                   : POS_CALC_W'(pos_reg);
        pos_sum  = pos_base + POS_CALC_W'(tin.encoder_delta);
        if (pos_sum > cpr_s)
            pos_wrap = pos_sum - cpr_s;
        else if (pos_sum < 0)
            pos_wrap = pos_sum + cpr_s;
        else
            pos_wrap = pos_sum;
        pos_next = pos_wrap[POS_W-1:0];
    end

    // Phase currents around midscale
    always_comb
    begin
        mid_s = CALC_W'(ADC_MID);
        cur_b = mid_s - signed'(CALC_W'(tin.adc_phase_b));
        cur_c = mid_s - signed'(CALC_W'(tin.adc_phase_c));
        cur_a = -(cur_b + cur_c);
    end

    // Symmetric Iq clamp
    always_comb
    begin
        req_s     = (IQ_W+1)'(tin.iq_request);
        lim_s     = signed'((IQ_W+1)'(cfg.iq_limit));
        neg_lim_s = -lim_s;
        if (req_s > lim_s)
            iq_next = lim_s[IQ_W-1:0];
        else if (req_s < neg_lim_s)
            iq_next = neg_lim_s[IQ_W-1:0];
        else
            iq_next = tin.iq_request;
    end

    // Sequencer, then bus protection on top of it
    always_comb
    begin
        mode_next  = mode_reg;
        fault_next = fault_reg;
        over_next  = over_reg;
        gate_next  = gate_reg;
        pwm_next   = pwm_reg;
        led_next   = led_reg;
        dis_next   = dis_reg;
        foc_next   = 1'b0;

        unique case (mode_reg)
            ST_READY, ST_STOP:
            begin
                if (tin.run_request)
                begin
                    fault_next = ERR_NONE;
                    mode_next  = ST_START;
                    led_next   = 1'b0;
                end
                else
                begin
                    gate_next = 1'b0;
                end
            end
            ST_START:
            begin
                gate_next = 1'b1;
                pwm_next  = 1'b1;
                mode_next = ST_RUN;
            end
            ST_RUN:
            begin
                foc_next = 1'b1;
                if (!tin.run_request)
                begin
                    mode_next = ST_STOP;
                    pwm_next  = 1'b0;
                    gate_next = 1'b0;
                    led_next  = 1'b0;
                end
                if (fault_reg != ERR_NONE)
                    mode_next = ST_ERROR;
            end
            ST_ERROR:
            begin
                pwm_next  = 1'b0;
                led_next  = 1'b1;
                gate_next = 1'b0;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        if (tin.adc_vbus < cfg.lv_threshold)
        begin
            fault_next = ERR_UNDER;
        end
        else if (tin.adc_vbus > cfg.ov_threshold)
        begin
            if (over_reg > cfg.ov_trip_count)
            begin
                fault_next = ERR_OVER;
                dis_next   = 1'b0;
            end
            if (over_reg != TICKS_MAX)
                over_next = over_reg + 1'b1;
        end
        else if (tin.adc_vbus > cfg.discharge_threshold)
        begin
            dis_next = 1'b1;
        end
        else
        begin
            dis_next  = 1'b0;
            over_next = '0;
        end
    end

    // Advance state once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            mode_reg  <= ST_READY;
            fault_reg <= ERR_NONE;
            over_reg  <= '0;
            gate_reg  <= 1'b0;
            pwm_reg   <= 1'b0;
            led_reg   <= 1'b0;
            dis_reg   <= 1'b0;
        end
        else if (step)
        begin
            pos_reg   <= pos_next;
            mode_reg  <= mode_next;
            fault_reg <= fault_next;
            over_reg  <= over_next;
            gate_reg  <= gate_next;
            pwm_reg   <= pwm_next;
            led_reg   <= led_next;
            dis_reg   <= dis_next;
        end
    end

    // Hold the per-item payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            cur_a_reg <= cur_a[CUR_W-1:0];
            cur_b_reg <= cur_b[CUR_W-1:0];
            cur_c_reg <= cur_c[CUR_W-1:0];
            iq_reg    <= iq_next;
            foc_reg   <= foc_next;
        end
    end

    always_comb
    begin
        res.position     = pos_reg;
        res.current_a    = cur_a_reg;
        res.current_b    = cur_b_reg;
        res.current_c    = cur_c_reg;
        res.iq_limited   = iq_reg;
        res.motor_state  = mode_code(mode_reg);
        res.error_code   = fault_reg;
        res.gate_enable  = gate_reg;
        res.pwm_enable   = pwm_reg;
        res.fault_led    = led_reg;
        res.discharge_on = dis_reg;
        res.foc_step     = foc_reg;
    end

endmodule

`default_nettype wire

// File: rtl/msu_out_stage.sv
// ============================================================================
// msu_out_stage - angle product and result register
// Multiplies the position by the angle step, saturates, and packs the
// finished result item into the output register.
// ============================================================================
`default_nettype none

module msu_out_stage (
    input  wire logic                           clk,
    input  wire logic                           load,
    input  wire msu_pkg::tick_res_t             res,
    input  wire logic [msu_pkg::WORD_W-1:0]     angle_step,
    output logic [msu_pkg::M_TDATA_W-1:0]       tdata
);
    import msu_pkg::*;

    localparam int PROD_W = POS_W - 1 + WORD_W;
    localparam int PAD_W  = M_TDATA_W - THETA_W - 3*CUR_W - IQ_W - STATE_W - ERR_W - 5;

    logic [PROD_W-1:0]     prod;
    logic [THETA_W-1:0]    theta;
    logic [M_TDATA_W-1:0]  tdata_reg, tdata_next;

    // Negative position gives zero angle; saturate above 32 bits
    always_comb
    begin
        prod = PROD_W'(res.position[POS_W-2:0]) * PROD_W'(angle_step);
        if (res.position[POS_W-1])
            theta = '0;
        else if (prod[PROD_W-1:THETA_W] != '0)
            theta = '1;
        else
            theta = prod[THETA_W-1:0];
    end

    // Pack fields, first field lowest
    assign tdata_next = {PAD_W'(0), res.foc_step, res.discharge_on, res.fault_led,
                         res.pwm_enable, res.gate_enable, res.error_code,
                         res.motor_state, res.iq_limited, res.current_c,
                         res.current_b, res.current_a, theta};

    always_ff @(posedge clk)
    begin
        if (load)
            tdata_reg <= tdata_next;
    end

    assign tdata = tdata_reg;

endmodule

`default_nettype wire

// File: rtl/msu_checker.sv
// ============================================================================
// msu_checker - port-level checks of the motor drive supervisor
// Watches the top level ports and flags sequencer and handshake slips.
// ============================================================================
`default_nettype none

module msu_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [msu_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready
);
    import msu_pkg::*;

    logic [STATE_W-1:0] st;
    logic [ERR_W-1:0]   err;
    logic               gate, pwm, led;

    assign st   = m_axis_tdata[89:87];
    assign err  = m_axis_tdata[91:90];
    assign gate = m_axis_tdata[92];
    assign pwm  = m_axis_tdata[93];
    assign led  = m_axis_tdata[94];

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result item changed");

    // Fault LED only in the error state
    a_led_error: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && led |-> st == MODE_ERROR)
        else $error("fault LED outside error state");

    // PWM never runs without the gate driver
    a_pwm_gate: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && pwm |-> gate)
        else $error("PWM enabled with gate off");

    // Error code stays within its defined codes
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> err == ERR_NONE || err == ERR_UNDER || err == ERR_OVER)
        else $error("undefined error code");

    // Error state is left only by reset
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && st == MODE_ERROR ##1 m_axis_tvalid
        |-> st == MODE_ERROR)
        else $error("left error state without reset");

endmodule

bind motor_drive_supervisor_unit msu_checker u_msu_checker (.*);

`default_nettype wire

// File: sim/motor_drive_supervisor_unit_test.sv
// ============================================================================
// motor_drive_supervisor_unit_test - self-checking bench of the supervisor
// Drives control ticks on the input stream and settings on the cfg channel,
// predicts every result item from a cycle-free model of position, currents,
// Iq clamp, sequencer and bus protection, and checks each output item in
// order. Phases vary settings and idling on both stream sides; the error
// state is entered only in the last phase since reset alone leaves it.
// ============================================================================

typedef struct packed {
    logic [31:0]        theta;
    logic signed [12:0] current_a;
    logic signed [12:0] current_b;
    logic signed [12:0] current_c;
    logic signed [15:0] iq_limited;
    logic [2:0]         motor_state;
    logic [1:0]         error_code;
    logic               gate_enable;
    logic               pwm_enable;
    logic               fault_led;
    logic               discharge_on;
    logic               foc_step;
} tick_result_t;

class supervisor_scoreboard;
    // settings
    logic [14:0] iq_clamp;
    logic [11:0] uv_level;
    logic [11:0] ov_level;
    logic [11:0] dump_level;
    logic [7:0]  trip_ticks;
    logic [15:0] rev_counts;
    logic [15:0] index_load;
    logic [15:0] rad_per_count;
    // tracked block state
    logic [17:0] position;
    logic [2:0]  mode;
    logic [1:0]  fault;
    logic [7:0]  over_ticks;
    logic        gate_on;
    logic        pwm_on;
    logic        led_on;
    logic        dump_on;

    tick_result_t expected_ticks[$];
    int failures;

    function new();
        iq_clamp      = msu_pkg::RST_IQ_LIMIT;
        uv_level      = msu_pkg::RST_LV_THRESHOLD;
        ov_level      = msu_pkg::RST_OV_THRESHOLD;
        dump_level    = msu_pkg::RST_DISCHARGE_THR;
        trip_ticks    = msu_pkg::RST_OV_TRIP_COUNT;
        rev_counts    = msu_pkg::RST_COUNTS_PER_REV;
        index_load    = msu_pkg::RST_INDEX_POSITION;
        rad_per_count = msu_pkg::RST_ANGLE_STEP;
        position      = '0;
        mode          = msu_pkg::MODE_READY;
        fault         = msu_pkg::ERR_NONE;
        over_ticks    = '0;
        gate_on       = 1'b0;
        pwm_on        = 1'b0;
        led_on        = 1'b0;
        dump_on       = 1'b0;
        failures      = 0;
    endfunction

    function void set_reg(msu_pkg::cfg_reg_t idx, logic [15:0] value);
        case (idx)
            msu_pkg::REG_IQ_LIMIT:       iq_clamp      = value[14:0];
            msu_pkg::REG_LV_THRESHOLD:   uv_level      = value[11:0];
            msu_pkg::REG_OV_THRESHOLD:   ov_level      = value[11:0];
            msu_pkg::REG_DISCHARGE_THR:  dump_level    = value[11:0];
            msu_pkg::REG_OV_TRIP_COUNT:  trip_ticks    = value[7:0];
            msu_pkg::REG_COUNTS_PER_REV: rev_counts    = value;
            msu_pkg::REG_INDEX_POSITION: index_load    = value;
            default:                     rad_per_count = value;
        endcase
    endfunction

    // Advance the model by one accepted tick and queue its result
    function void note_tick(msu_pkg::tick_in_t t);
        int           count;
        int           cur_a;
        int           cur_b;
        int           cur_c;
        int           clamp;
        int           iq;
        longint       prod;
        tick_result_t r;

        r = '0;

        // encoder position with a single wrap, kept in 18 bits
        count = t.index_pulse ? int'(index_load) : int'($signed(position));
        count = count + int'($signed(t.encoder_delta));
        if (count > int'(rev_counts))
            count = count - int'(rev_counts);
        else if (count < 0)
            count = count + int'(rev_counts);
        position = count[17:0];
        count = int'($signed(position));
        if (count < 0) begin
            r.theta = '0;
        end
        else begin
            prod = longint'(count) * longint'(rad_per_count);
            r.theta = (prod > 64'd4294967295) ? 32'hFFFF_FFFF : prod[31:0];
        end

        // phase currents and Iq clamp
        cur_b = msu_pkg::ADC_MID - int'(t.adc_phase_b);
        cur_c = msu_pkg::ADC_MID - int'(t.adc_phase_c);
        cur_a = -(cur_b + cur_c);
        r.current_a = cur_a[12:0];
        r.current_b = cur_b[12:0];
        r.current_c = cur_c[12:0];
        clamp = int'(iq_clamp);
        iq = int'($signed(t.iq_request));
        if (iq > clamp)
            iq = clamp;
        else if (iq < -clamp)
            iq = -clamp;
        r.iq_limited = iq[15:0];

        // sequencer
        case (mode)
            msu_pkg::MODE_READY, msu_pkg::MODE_STOP:
            begin
                if (t.run_request) begin
                    fault  = msu_pkg::ERR_NONE;
                    mode   = msu_pkg::MODE_START;
                    led_on = 1'b0;
                end
                else begin
                    gate_on = 1'b0;
                end
            end
            msu_pkg::MODE_START:
            begin
                gate_on = 1'b1;
                pwm_on  = 1'b1;
                mode    = msu_pkg::MODE_RUN;
            end
            msu_pkg::MODE_RUN:
            begin
                r.foc_step = 1'b1;
                if (!t.run_request) begin
                    mode    = msu_pkg::MODE_STOP;
                    pwm_on  = 1'b0;
                    gate_on = 1'b0;
                    led_on  = 1'b0;
                end
                // a pending fault beats a stop request
                if (fault != msu_pkg::ERR_NONE)
                    mode = msu_pkg::MODE_ERROR;
            end
            msu_pkg::MODE_ERROR:
            begin
                pwm_on  = 1'b0;
                led_on  = 1'b1;
                gate_on = 1'b0;
            end
            default:
            begin
            end
        endcase

        // bus protection, seen by the sequencer on the next tick
        if (t.adc_vbus < uv_level) begin
            fault = msu_pkg::ERR_UNDER;
        end
        else if (t.adc_vbus > ov_level) begin
            if (over_ticks > trip_ticks) begin
                fault   = msu_pkg::ERR_OVER;
                dump_on = 1'b0;
            end
            if (over_ticks != msu_pkg::TICKS_MAX)
                over_ticks = over_ticks + 8'd1;
        end
        else if (t.adc_vbus > dump_level) begin
            dump_on = 1'b1;
        end
        else begin
            dump_on    = 1'b0;
            over_ticks = '0;
        end

        r.motor_state  = mode;
        r.error_code   = fault;
        r.gate_enable  = gate_on;
        r.pwm_enable   = pwm_on;
        r.fault_led    = led_on;
        r.discharge_on = dump_on;
        expected_ticks.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            failures++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // Unpack one result item and compare it with the oldest prediction
    function void check_tick_result(logic [msu_pkg::M_TDATA_W-1:0] d);
        tick_result_t got;
        tick_result_t want;

        got.theta        = d[31:0];
        got.current_a    = d[44:32];
        got.current_b    = d[57:45];
        got.current_c    = d[70:58];
        got.iq_limited   = d[86:71];
        got.motor_state  = d[89:87];
        got.error_code   = d[91:90];
        got.gate_enable  = d[92];
        got.pwm_enable   = d[93];
        got.fault_led    = d[94];
        got.discharge_on = d[95];
        got.foc_step     = d[96];
        if (expected_ticks.size() == 0) begin
            failures++;
            $display("%0t: result item with none expected, expected nothing actual %h",
                     $time, d);
            return;
        end
        want = expected_ticks.pop_front();
        compare_field("theta", want.theta, got.theta);
        compare_field("current_a", want.current_a, got.current_a);
        compare_field("current_b", want.current_b, got.current_b);
        compare_field("current_c", want.current_c, got.current_c);
        compare_field("iq_limited", want.iq_limited, got.iq_limited);
        compare_field("motor_state", want.motor_state, got.motor_state);
        compare_field("error_code", want.error_code, got.error_code);
        compare_field("gate_enable", want.gate_enable, got.gate_enable);
        compare_field("pwm_enable", want.pwm_enable, got.pwm_enable);
        compare_field("fault_led", want.fault_led, got.fault_led);
        compare_field("discharge_on", want.discharge_on, got.discharge_on);
        compare_field("foc_step", want.foc_step, got.foc_step);
    endfunction
endclass

module motor_drive_supervisor_unit_test;

    localparam int PHASES          = 9;
    localparam int TICKS_PER_PHASE = 115;
    localparam int TICKS_AT_END    = 130;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 2000;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic [msu_pkg::S_TDATA_W-1:0]     s_axis_tdata;
    logic                              s_axis_tuser;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [msu_pkg::M_TDATA_W-1:0]     m_axis_tdata;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [msu_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [msu_pkg::CFG_DATA_W-1:0]    cfg_data;

    supervisor_scoreboard sb;
    int          idle_pct;
    int          stall_pct;
    int          quiet_cycles;
    logic [15:0] setting_vals [8];

    motor_drive_supervisor_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Stall the result side at random
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Check result items and watch for a hung pipeline
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (m_axis_tvalid && m_axis_tready)
            sb.check_tick_result(m_axis_tdata);
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one tick item, hold it until accepted; returns at a falling edge
    task automatic drive_tick(input msu_pkg::tick_in_t t);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tdata  <= {3'b0, t.iq_request, t.run_request, t.adc_vbus,
                          t.adc_phase_c, t.adc_phase_b, t.encoder_delta};
        s_axis_tuser  <= t.index_pulse;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_tick(t);
        @(negedge clk);
    endtask

    task automatic drive_fields(input int delta, input bit index, input int adc_b,
                                input int adc_c, input int vbus, input bit start,
                                input int iq);
        msu_pkg::tick_in_t t;

        t.encoder_delta = delta[15:0];
        t.index_pulse   = index;
        t.adc_phase_b   = adc_b[11:0];
        t.adc_phase_c   = adc_c[11:0];
        t.adc_vbus      = vbus[11:0];
        t.run_request   = start;
        t.iq_request    = iq[15:0];
        drive_tick(t);
    endtask

    // Drop the input valid and drain every outstanding result
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_ticks.size() != 0)
            @(negedge clk);
    endtask

    // Write all eight registers back to back
    task automatic load_settings();
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= msu_pkg::cfg_reg_t'(i);
            cfg_data  <= setting_vals[i];
            do @(posedge clk); while (!cfg_ready);
            sb.set_reg(msu_pkg::cfg_reg_t'(i), setting_vals[i]);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic void pick_settings(input int phase);
        case (phase)
            0: setting_vals = '{16'h7FFF, 16'h0000, 16'h0FFF, 16'h0FFF,
                                16'h00FF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            1: setting_vals = '{16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                16'h0000, 16'h0001, 16'h0000, 16'h0000};
            PHASES - 1:
            begin
                setting_vals[msu_pkg::REG_IQ_LIMIT]       = msu_pkg::RST_IQ_LIMIT;
                setting_vals[msu_pkg::REG_LV_THRESHOLD]   = msu_pkg::RST_LV_THRESHOLD;
                setting_vals[msu_pkg::REG_OV_THRESHOLD]   = msu_pkg::RST_OV_THRESHOLD;
                setting_vals[msu_pkg::REG_DISCHARGE_THR]  = msu_pkg::RST_DISCHARGE_THR;
                setting_vals[msu_pkg::REG_OV_TRIP_COUNT]  = msu_pkg::RST_OV_TRIP_COUNT;
                setting_vals[msu_pkg::REG_COUNTS_PER_REV] = msu_pkg::RST_COUNTS_PER_REV;
                setting_vals[msu_pkg::REG_INDEX_POSITION] = msu_pkg::RST_INDEX_POSITION;
                setting_vals[msu_pkg::REG_ANGLE_STEP]     = msu_pkg::RST_ANGLE_STEP;
            end
            default:
            begin
                setting_vals[msu_pkg::REG_IQ_LIMIT]      = $urandom_range(0, 32767);
                setting_vals[msu_pkg::REG_LV_THRESHOLD]  = $urandom_range(0, 1500);
                setting_vals[msu_pkg::REG_OV_THRESHOLD]  = $urandom_range(2800, 4095);
                setting_vals[msu_pkg::REG_DISCHARGE_THR] = $urandom_range(2000, 4095);
                setting_vals[msu_pkg::REG_OV_TRIP_COUNT] = $urandom_range(0, 40);
                case ($urandom_range(0, 2))
                    0:       setting_vals[msu_pkg::REG_COUNTS_PER_REV] = $urandom_range(1, 50);
                    1:       setting_vals[msu_pkg::REG_COUNTS_PER_REV] = $urandom_range(1, 4000);
                    default: setting_vals[msu_pkg::REG_COUNTS_PER_REV] = $urandom_range(1, 65535);
                endcase
                setting_vals[msu_pkg::REG_INDEX_POSITION] = $urandom_range(0, 65535);
                setting_vals[msu_pkg::REG_ANGLE_STEP]     = $urandom_range(0, 65535);
                // zero modulus: the wrap adds or subtracts nothing
                if (phase == 2)
                    setting_vals[msu_pkg::REG_COUNTS_PER_REV] = 16'd0;
            end
        endcase
    endfunction

    // Random tick; when guarded, keep the bus short of a fault once the drive
    // leaves ready or stopped so that no fault ever reaches the running state
    function automatic msu_pkg::tick_in_t next_tick(input bit guarded);
        msu_pkg::tick_in_t t;
        int clamp;
        int uv;
        int ov;

        clamp = int'(sb.iq_clamp);
        uv    = int'(sb.uv_level);
        ov    = int'(sb.ov_level);
        case ($urandom_range(0, 9))
            0:       t.encoder_delta = 16'h7FFF;
            1:       t.encoder_delta = 16'h8000;
            2, 3:    t.encoder_delta = $urandom_range(0, 65535);
            default: t.encoder_delta = 16'($urandom_range(0, 400) - 200);
        endcase
        t.index_pulse = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 7))
            0:       t.adc_phase_b = 12'h000;
            1:       t.adc_phase_b = 12'hFFF;
            default: t.adc_phase_b = $urandom_range(0, 4095);
        endcase
        case ($urandom_range(0, 7))
            0:       t.adc_phase_c = 12'h000;
            1:       t.adc_phase_c = 12'hFFF;
            default: t.adc_phase_c = $urandom_range(0, 4095);
        endcase
        t.run_request = ($urandom_range(0, 99) < 88);
        if ($urandom_range(0, 1) == 0)
            t.iq_request = $urandom_range(0, 65535);
        else
            t.iq_request = 16'($urandom_range(0, 2 * clamp + 200) - clamp - 100);

        if (!guarded || ((sb.mode == msu_pkg::MODE_READY || sb.mode == msu_pkg::MODE_STOP)
                         && !t.run_request)) begin
            case ($urandom_range(0, 6))
                0:       t.adc_vbus = (uv > 0) ? $urandom_range(0, uv - 1) : 12'd0;
                1:       t.adc_vbus = (ov < 4095) ? $urandom_range(ov + 1, 4095) : 12'hFFF;
                default: t.adc_vbus = $urandom_range(0, 4095);
            endcase
        end
        else if (ov < 4095 && sb.over_ticks <= sb.trip_ticks && $urandom_range(0, 3) == 0) begin
            t.adc_vbus = $urandom_range(ov + 1, 4095);
        end
        else begin
            t.adc_vbus = $urandom_range(uv, ov);
        end
        return t;
    endfunction

    initial
    begin
        sb = new();
        idle_pct      = 0;
        stall_pct     = 0;
        quiet_cycles  = 0;
        rst_n         = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tvalid = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed ticks under reset settings: field extremes, bus faults
        // while idle, the start/run/stop sequence and both position wraps
        drive_fields(32767, 0, 0, 4095, 2000, 0, 32767);
        drive_fields(-32768, 0, 4095, 0, 2000, 0, -32768);
        drive_fields(-32768, 0, 2048, 2048, 0, 0, 2560);
        drive_fields(0, 1, 1, 4094, 4095, 0, -2560);
        repeat (6) drive_fields(1, 0, 2048, 2048, 4095, 0, 0);
        drive_fields(0, 0, 2048, 2048, 3000, 0, 0);
        drive_fields(0, 0, 2048, 2048, 2000, 0, 0);
        drive_fields(10, 0, 2047, 2049, 2000, 1, 100);
        drive_fields(10, 0, 2049, 2047, 2000, 1, 2561);
        drive_fields(-2000, 1, 2048, 2048, 2000, 1, -2561);
        drive_fields(700, 1, 2048, 2048, 2000, 1, 0);
        drive_fields(0, 0, 2048, 2048, 2000, 0, 0);
        drive_fields(0, 0, 2048, 2048, 2000, 0, 0);
        drive_fields(0, 0, 2048, 2048, 2000, 1, 0);
        drive_fields(0, 0, 2048, 2048, 2000, 1, 0);
        drive_fields(5, 0, 0, 0, 3000, 1, 32767);
        drive_fields(5, 0, 4095, 4095, 2000, 1, -32768);

        // Random phases, each with fresh settings and its own idling mix
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            idle_pct  = 0;
            stall_pct = 0;
            pick_settings(phase);
            load_settings();
            case (phase % 4)
                1:       idle_pct  = 68;
                2:       stall_pct = 68;
                3:
                begin
                    idle_pct  = 6;
                    stall_pct = 6;
                end
                default:
                begin
                end
            endcase
            if (phase == PHASES - 1) begin
                // reach running, then let a bus fault beat a stop request
                while (sb.mode != msu_pkg::MODE_RUN)
                    drive_fields(0, 0, 2048, 2048, 2000, 1, 0);
                drive_fields(3, 0, 2048, 2048, 0, 1, 0);
                drive_fields(3, 0, 2048, 2048, 2000, 0, 0);
                repeat (TICKS_AT_END) drive_tick(next_tick(1'b0));
            end
            else begin
                repeat (TICKS_PER_PHASE) drive_tick(next_tick(1'b1));
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.failures == 0 && sb.expected_ticks.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
